// ===== hw/rtl/stuffed_frame_decoder_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef STUFFED_FRAME_DECODER_MACROS_SVH
`define STUFFED_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

  localparam int MAX_FRAME  = 512;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;
  localparam int LEFT_W     = $clog2(MAX_FRAME + 2);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 24;

  localparam logic [LEFT_W-1:0] MAX_LEN = LEFT_W'(MAX_FRAME);

  localparam logic [BYTE_W-1:0] START_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'd1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2
  } sfd_phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]  response_length;
    logic [BYTE_W-1:0] line_byte;
  } sfd_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_done;
    logic              checksum_good;
  } sfd_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfd_in_reg.sv =====
`default_nettype none

module sfd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  input  wire sfd_pkg::sfd_item_t req_item,
  output logic                   req_ready,
  input  wire logic              adv,
  output logic                   stage_valid,
  output sfd_pkg::sfd_item_t     stage_item
);

  logic               valid_r;
  logic               valid_nxt;
  sfd_pkg::sfd_item_t item_r;
  logic               load;

  // A new request may enter when the stage is empty or is moving on.
  assign req_ready = !valid_r || adv;
  assign load      = req_valid && req_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= req_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_core.sv =====
`default_nettype none

module sfd_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               fire,
  input  wire sfd_pkg::sfd_item_t                 item,
  output logic                                    res_valid,
  output sfd_pkg::sfd_result_t                    res
);

  sfd_pkg::sfd_phase_t             phase_r;
  sfd_pkg::sfd_phase_t             phase_nxt;
  logic [sfd_pkg::LEFT_W-1:0]      left_r;
  logic [sfd_pkg::LEFT_W-1:0]      left_nxt;
  logic [sfd_pkg::BYTE_W-1:0]      sum_r;
  logic [sfd_pkg::BYTE_W-1:0]      sum_nxt;
  logic [sfd_pkg::BYTE_W-1:0]      start_r;
  logic [sfd_pkg::BYTE_W-1:0]      escape_r;

  logic [sfd_pkg::BYTE_W-1:0]      dec_byte;
  logic                            take;
  logic                            esc_go;
  logic                            open;
  logic                            skip;
  logic [sfd_pkg::LEFT_W-1:0]      len_ext;
  logic [sfd_pkg::LEFT_W-1:0]      open_left;
  logic [sfd_pkg::LEFT_W-1:0]      left_eff;
  logic [sfd_pkg::BYTE_W-1:0]      sum_eff;
  logic                            more;

  // Classify the byte against the current phase.
  always_comb begin
    dec_byte = item.line_byte;
    take     = 1'b0;
    esc_go   = 1'b0;
    open     = 1'b0;
    skip     = 1'b0;
    case (phase_r)
      sfd_pkg::PH_ESC: begin
        dec_byte = ~item.line_byte;
        take     = 1'b1;
      end
      sfd_pkg::PH_BODY: begin
        if (item.line_byte == escape_r) begin
          esc_go = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        if (item.line_byte == start_r) begin
          skip = 1'b1;
        end else begin
          open = 1'b1;
          if (item.line_byte == escape_r) begin
            esc_go = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end
    endcase

    len_ext   = sfd_pkg::LEFT_W'(item.response_length);
    open_left = ((len_ext > sfd_pkg::MAX_LEN) ? sfd_pkg::MAX_LEN : len_ext)
                + sfd_pkg::LEFT_W'(1);
    left_eff  = open ? open_left : left_r;
    sum_eff   = open ? '0 : sum_r;
    more      = left_eff > sfd_pkg::LEFT_W'(1);
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    if (fire) begin
      if (skip) begin
        phase_nxt = sfd_pkg::PH_HUNT;
      end
      if (open) begin
        left_nxt = open_left;
        sum_nxt  = '0;
      end
      if (esc_go) begin
        phase_nxt = sfd_pkg::PH_ESC;
      end
      if (take) begin
        if (more) begin
          phase_nxt = sfd_pkg::PH_BODY;
          left_nxt  = left_eff - sfd_pkg::LEFT_W'(1);
          sum_nxt   = sum_eff + dec_byte;
        end else begin
          phase_nxt = sfd_pkg::PH_HUNT;
          left_nxt  = '0;
          sum_nxt   = '0;
        end
      end
    end
  end

  // Result for this byte; the checksum byte closes the frame.
  always_comb begin
    res_valid         = take;
    res.payload_byte  = '0;
    res.frame_done    = 1'b0;
    res.checksum_good = 1'b0;
    if (more) begin
      res.payload_byte = dec_byte;
    end else begin
      res.frame_done    = 1'b1;
      res.checksum_good = (sum_eff == dec_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfd_pkg::PH_HUNT;
      left_r  <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= sfd_pkg::START_RESET;
      escape_r <= sfd_pkg::ESCAPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::CFG_START:  start_r  <= cfg_wdata;
        sfd_pkg::CFG_ESCAPE: escape_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_out_reg.sv =====
`default_nettype none

module sfd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire sfd_pkg::sfd_result_t res,
  input  wire logic                 take,
  output logic                      busy,
  output logic                      valid,
  output sfd_pkg::sfd_result_t      data
);

  logic                 valid_r;
  logic                 valid_nxt;
  sfd_pkg::sfd_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  // Full and not being drained this cycle.
  assign busy  = valid_r && !take;
  assign valid = valid_r;
  assign data  = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stuffed_frame_decoder.sv =====
// Byte-stuffed frame receiver: takes one line byte per cycle, skips start
// bytes while hunting, removes escapes (inverting the byte after each one),
// emits every decoded payload byte and, for the checksum byte, one
// end-of-frame request flagged by out_tlast with out_tuser telling whether the
// 8-bit additive sum matched. A byte is accepted every cycle as long as the
// output side keeps up; a request passes through the input register and
// then the result register, with the frame state updated in one pass
// between them. Escape bytes and skipped start bytes produce no request.
// Configuration writes take effect in the cycle after cfg_we and should be
// made while no bytes are in flight.
`default_nettype none
`include "stuffed_frame_decoder_macros.svh"

module stuffed_frame_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: line_byte [7:0], response_length [16:8], zero [23:17]
  input  wire logic [sfd_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: payload_byte [7:0]
  output logic [sfd_pkg::BYTE_W-1:0]               out_tdata,
  output logic                                     out_tlast,
  // out_tuser: checksum_good [0]
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sfd_pkg::sfd_item_t   in_item;
  sfd_pkg::sfd_item_t   stage_item;
  logic                 stage_valid;
  logic                 stage_adv;
  logic                 res_valid;
  sfd_pkg::sfd_result_t res;
  logic                 out_busy;
  sfd_pkg::sfd_result_t out_data;

  assign in_item.line_byte       = in_tdata[sfd_pkg::BYTE_W-1:0];
  assign in_item.response_length =
    in_tdata[sfd_pkg::BYTE_W+sfd_pkg::LEN_W-1:sfd_pkg::BYTE_W];

  assign stage_adv = stage_valid && !out_busy;

  sfd_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_item    (in_item),
    .req_ready   (in_tready),
    .adv         (stage_adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  sfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (stage_adv),
    .item      (stage_item),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (stage_adv && res_valid),
    .res   (res),
    .take  (out_tready),
    .busy  (out_busy),
    .valid (out_tvalid),
    .data  (out_data)
  );

  assign out_tdata = out_data.payload_byte;
  assign out_tlast = out_data.frame_done;
  assign out_tuser = out_data.checksum_good;

  `SFD_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid && !stage_adv, stage_valid && $stable(stage_item), "stalled stage lost its byte")
  `SFD_ASSERT_NOW(a_good_only_on_done, clk, rst_n, out_tvalid && out_tuser, out_tlast, "checksum flag on a payload request")
  `SFD_ASSERT_NOW(a_done_zero_payload, clk, rst_n, out_tvalid && out_tlast, out_tdata == '0, "end-of-frame request carries payload")

endmodule

`default_nettype wire

// ===== tb/sv/stuffed_frame_decoder_tb.sv =====
module stuffed_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_AT       = 200;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CALM_FROM     = 420;
  localparam int unsigned CALM_TO       = 540;
  localparam int unsigned MAX_REPORTS   = 200;

  // Tracks the deframer state and keeps the decoded bytes and frame ends still owed.
  class frame_scoreboard;
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] escape_val;
    sfd_phase_t        state;
    logic [LEFT_W-1:0] bytes_to_go;
    logic [BYTE_W-1:0] sum_so_far;
    sfd_result_t       pending_q[$];
    int unsigned       errors;
    int unsigned       line_bytes;
    int unsigned       payload_bytes;
    int unsigned       frames;
    int unsigned       good_frames;

    function new();
      start_val   = START_RESET;
      escape_val  = ESCAPE_RESET;
      state       = PH_HUNT;
      bytes_to_go = '0;
      sum_so_far  = '0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    function void decode_byte(logic [BYTE_W-1:0] d);
      if (bytes_to_go > 1) begin
        sum_so_far += d;
        bytes_to_go--;
        state = PH_BODY;
        pending_q.push_back('{payload_byte: d, frame_done: 1'b0, checksum_good: 1'b0});
      end else begin
        pending_q.push_back('{payload_byte: '0, frame_done: 1'b1,
                              checksum_good: (sum_so_far == d)});
        state       = PH_HUNT;
        bytes_to_go = '0;
        sum_so_far  = '0;
      end
    endfunction

    function void note_request(sfd_item_t it);
      line_bytes++;
      case (state)
        PH_ESC: decode_byte(~it.line_byte);
        PH_BODY: begin
          if (it.line_byte == escape_val) state = PH_ESC;
          else decode_byte(it.line_byte);
        end
        default: begin
          if (it.line_byte != start_val) begin
            bytes_to_go = (it.response_length > MAX_FRAME) ? MAX_LEN + 1'b1 :
                          LEFT_W'(it.response_length) + 1'b1;
            sum_so_far  = '0;
            if (it.line_byte == escape_val) state = PH_ESC;
            else decode_byte(it.line_byte);
          end
        end
      endcase
    endfunction

    task check_result(sfd_result_t got);
      sfd_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected request: byte %02h last %0b good %0b",
                         got.payload_byte, got.frame_done, got.checksum_good));
        return;
      end
      want = pending_q.pop_front();
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload byte %02h, expected %02h",
                         got.payload_byte, want.payload_byte));
      if (got.frame_done !== want.frame_done)
        report($sformatf("end-of-frame flag %0b, expected %0b",
                         got.frame_done, want.frame_done));
      if (got.checksum_good !== want.checksum_good)
        report($sformatf("checksum flag %0b, expected %0b",
                         got.checksum_good, want.checksum_good));
      if (want.frame_done) begin
        frames++;
        if (want.checksum_good) good_frames++;
      end else begin
        payload_bytes++;
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frame_scoreboard       sb = new();
  int unsigned           n_in = 0;
  int unsigned           n_sent = 0;
  int unsigned           stall_cnt = 0;
  logic [BYTE_W-1:0]     cur_start = START_RESET;
  logic [BYTE_W-1:0]     cur_escape = ESCAPE_RESET;

  stuffed_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Input requests are noted before results are checked, so the order within a step is fixed.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(sfd_item_t'(in_tdata[$bits(sfd_item_t)-1:0]));
        n_in <= n_in + 1;
      end
      if (out_tvalid && out_tready)
        sb.check_result('{payload_byte: out_tdata, frame_done: out_tlast,
                          checksum_good: out_tuser});
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  function automatic bit take_gap();
    if (n_in >= CALM_FROM && n_in < CALM_TO) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  // The receiver holds off once for a long stretch so the block backs up into its input.
  initial begin : rx_pacing
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_in >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= !take_gap();
    end
  end

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom_range(1, 511));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(15))
      0: return cur_start;
      1: return cur_escape;
      2: return 8'h00;
      3: return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len);
    sfd_item_t it;
    it.line_byte       = b;
    it.response_length = len;
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'(it);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // Sends one decoded byte, escaping it where needed and now and then where not.
  task automatic send_decoded(input logic [BYTE_W-1:0] want, input bit opening,
                              input logic [LEN_W-1:0] len, output logic [BYTE_W-1:0] sent);
    logic [BYTE_W-1:0] d;
    bit                esc;
    logic [LEN_W-1:0]  lead_len;
    d = want;
    // With equal codes an opening escape would be skipped, so the byte goes out plain.
    if (opening && cur_start == cur_escape) begin
      if (d == cur_start) d = d ^ 8'h01;
      esc = 1'b0;
    end else begin
      esc = (d == cur_escape) || (opening && d == cur_start) || ($urandom_range(9) == 0);
    end
    lead_len = opening ? len : rand_len();
    if (esc) begin
      send_item(cur_escape, lead_len);
      send_item(~d, rand_len());
    end else begin
      send_item(d, lead_len);
    end
    sent = d;
  endtask

  task automatic send_frame(input int unsigned len, input bit bad_sum, input bit cut);
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] got;
    logic [BYTE_W-1:0] sum;
    sum = '0;
    repeat ($urandom_range(0, 2)) send_item(cur_start, rand_len());
    for (int i = 0; i < len; i++) begin
      d = pick_byte();
      send_decoded(d, i == 0, LEN_W'(len), got);
      sum += got;
    end
    if (!cut) begin
      d = bad_sum ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
      send_decoded(d, len == 0, LEN_W'(len), got);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5)) send_item(pick_byte(), LEN_W'($urandom_range(1, 8)));
  endtask

  task automatic random_phase(input int unsigned budget, input bit with_big);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    stop_at = n_sent + budget;
    if (with_big) send_frame($urandom_range(256, 300), 1'b0, 1'b0);
    while (n_sent < stop_at) begin
      r   = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (r < 72) send_frame(len, $urandom_range(3) == 0, 1'b0);
      else if (r < 90) send_noise();
      else send_frame(len, 1'b0, 1'b1);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(input logic [BYTE_W-1:0] start_v, input logic [BYTE_W-1:0] esc_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= start_v;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE;
    cfg_wdata <= esc_v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_start     = start_v;
    cur_escape    = esc_v;
    sb.start_val  = start_v;
    sb.escape_val = esc_v;
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] rand_start;
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_START;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start bytes are skipped while hunting.
    send_item(8'hAA, 9'd511);
    send_item(8'hAA, 9'd1);
    // Payload 00 FF, the FF escaped, then the checksum FF, escaped as well.
    send_item(8'h00, 9'd2);
    send_item(cur_escape, 9'd511);
    send_item(8'h00, 9'd1);
    send_item(cur_escape, 9'd1);
    send_item(8'h00, 9'd511);
    // An escape opens the frame.
    send_item(cur_escape, 9'd1);
    send_item(8'hED, 9'd3);
    send_item(8'h12, 9'd3);
    // A start byte inside a frame is plain data.
    send_item(8'h01, 9'd2);
    send_item(8'hAA, 9'd1);
    send_item(8'hAB, 9'd1);
    // A second escape right after the first is inverted as data.
    send_item(8'h05, 9'd2);
    send_item(cur_escape, 9'd1);
    send_item(cur_escape, 9'd1);
    send_item(8'h05, 9'd1);
    // Zero-length frames: the first byte is already the checksum.
    send_item(8'h00, 9'd0);
    send_item(8'h33, 9'd0);
    // Wrong checksum.
    send_item(8'h7F, 9'd1);
    send_item(8'h80, 9'd1);
    random_phase(100, 1'b1);
    settle();

    set_codes(8'h00, 8'hFF);
    random_phase(100, 1'b0);
    settle();

    set_codes(8'hFF, 8'h00);
    random_phase(100, 1'b0);
    settle();

    // Equal codes: skipped while hunting, an escape inside a frame.
    set_codes(8'h7E, 8'h7E);
    send_item(8'h7E, 9'd1);
    send_item(8'h10, 9'd2);
    send_item(8'h7E, 9'd1);
    send_item(8'h81, 9'd1);
    send_item(8'h8E, 9'd1);
    random_phase(100, 1'b0);
    settle();

    rand_start = BYTE_W'($urandom);
    set_codes(rand_start, ($urandom_range(3) == 0) ? rand_start : BYTE_W'($urandom));
    random_phase(100, 1'b0);
    settle();

    $display("Run covered %0d line bytes: %0d payload bytes and %0d frames, %0d with good sums.",
             sb.line_bytes, sb.payload_bytes, sb.frames, sb.good_frames);
    $display("Codes used: reset pair, 00/FF, FF/00, equal values and %02h/%02h; one long frame.",
             cur_start, cur_escape);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_in_reg.sv
hw/rtl/sfd_core.sv
hw/rtl/sfd_out_reg.sv
hw/rtl/stuffed_frame_decoder.sv
tb/sv/stuffed_frame_decoder_tb.sv
